FILE: sv/pid_steering_controller_macros.svh
// ----------------------------------------------------------------------------
// PID steering controller assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PID_STEERING_CONTROLLER_MACROS_SVH
`define PID_STEERING_CONTROLLER_MACROS_SVH

// check prop in the same cycle as cond
`define PSC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("psc: same-cycle check failed");

// check prop in the cycle after cond
`define PSC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("psc: next-cycle check failed");

`endif

FILE: sv/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Payload types, register map, fixed-point constants and the microprogram
// of the PID steering controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int TURN_BITS   = 9;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int RATE_W      = 14;

  // fixed-point positions: integral is Q.17, final sum is Q.29
  localparam int INT_FRAC    = 17;
  localparam int OUT_FRAC    = 29;
  localparam int TURN_LIMIT  = 200;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FRAC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 3'd4;

  localparam logic [CFG_W-1:0]  GAIN_P_RST = 16'd1229;
  localparam logic [CFG_W-1:0]  GAIN_I_RST = 16'd819;
  localparam logic [CFG_W-1:0]  GAIN_D_RST = 16'd0;
  localparam logic [CFG_W-1:0]  PERIOD_RST = 16'd262;
  localparam logic [RATE_W-1:0] RATE_RST   = 14'd250;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_value;
    logic [SAMPLE_BITS-1:0] target_value;
  } psc_in_t;

  typedef struct packed {
    logic signed [TURN_BITS-1:0] turn_value;
    logic                        was_clamped;
  } psc_out_t;

  // multiplier operand selects
  localparam logic [2:0] MUL_EP  = 3'd0;  // (e + prev) * period
  localparam logic [2:0] MUL_P   = 3'd1;  // e * gain_p
  localparam logic [2:0] MUL_DR  = 3'd2;  // (e - prev) * rate
  localparam logic [2:0] MUL_D   = 3'd3;  // product * gain_d
  localparam logic [2:0] MUL_ILO = 3'd4;  // integral low half * gain_i
  localparam logic [2:0] MUL_IHI = 3'd5;  // integral high half * gain_i

  // accumulator operations
  localparam logic [2:0] ACC_NOP    = 3'd0;
  localparam logic [2:0] ACC_INTEG  = 3'd1;  // saturating integral update
  localparam logic [2:0] ACC_LOAD_Q = 3'd2;  // acc = product << INT_FRAC
  localparam logic [2:0] ACC_ADD_Q  = 3'd3;  // acc += product << INT_FRAC
  localparam logic [2:0] ACC_ADD    = 3'd4;  // acc += product
  localparam logic [2:0] ACC_ADD_HI = 3'd5;  // acc += product << low half width
  localparam logic [2:0] ACC_ROUND  = 3'd6;  // add rounding bias, latch clamp flags

  localparam logic JMP_NEXT = 1'b0;
  localparam logic JMP_DONE = 1'b1;  // emit when output is free, else hold

  localparam int STEP_W = 4;

  typedef struct packed {
    logic [2:0] mul_op;
    logic [2:0] acc_op;
    logic       jmp;
  } psc_uword_t;

  function automatic psc_uword_t psc_ucode(input logic [STEP_W-1:0] step);
    psc_uword_t uw;
    unique case (step)
      4'd0:    uw = '{mul_op: MUL_EP,  acc_op: ACC_NOP,    jmp: JMP_NEXT};
      4'd1:    uw = '{mul_op: MUL_P,   acc_op: ACC_INTEG,  jmp: JMP_NEXT};
      4'd2:    uw = '{mul_op: MUL_DR,  acc_op: ACC_LOAD_Q, jmp: JMP_NEXT};
      4'd3:    uw = '{mul_op: MUL_D,   acc_op: ACC_NOP,    jmp: JMP_NEXT};
      4'd4:    uw = '{mul_op: MUL_ILO, acc_op: ACC_ADD_Q,  jmp: JMP_NEXT};
      4'd5:    uw = '{mul_op: MUL_IHI, acc_op: ACC_ADD,    jmp: JMP_NEXT};
      4'd6:    uw = '{mul_op: MUL_EP,  acc_op: ACC_ADD_HI, jmp: JMP_NEXT};
      4'd7:    uw = '{mul_op: MUL_EP,  acc_op: ACC_ROUND,  jmp: JMP_NEXT};
      default: uw = '{mul_op: MUL_EP,  acc_op: ACC_NOP,    jmp: JMP_DONE};
    endcase
    return uw;
  endfunction

endpackage

FILE: sv/pid_steering_controller.sv
// ----------------------------------------------------------------------------
// pid_steering_controller
// PID steering controller with trapezoidal integral, clamp and rounding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one sensor sample and
//   its target per transaction. Result channel out_valid / out_stall /
//   out_data returns one steering command and a clamp flag per input.
//   Gains, period and rate are written through cfg_we / cfg_index /
//   cfg_wdata while the block is idle.
//   A new input is taken only when the previous item has finished; a
//   microprogram of nine steps drives one shared 17-bit by 26-bit multiplier
//   through six products, the accumulation and the rounding.
//   Reset (rst_n low, synchronous) restores register defaults and clears the
//   previous error, the integral and the output valid flag.
//   A stalled result holds in the output register while the next input is
//   computed; that item then waits in its last step until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_steering_controller #(
  parameter int INTEGRAL_BITS = 40
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  psc_pkg::psc_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output psc_pkg::psc_out_t                     out_data,
  input  logic                                  cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]             cfg_wdata
);
  import psc_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int EW    = SB + 1;
  localparam int IB    = INTEGRAL_BITS;
  localparam int LO_W  = IB / 2;
  localparam int HI_W  = IB - LO_W;
  localparam int AW    = CFG_W + 1;
  localparam int MB_A  = (SB + 16 > LO_W + 1) ? SB + 16 : LO_W + 1;
  localparam int MB    = (MB_A > HI_W) ? MB_A : HI_W;
  localparam int PW    = AW + MB;
  localparam int SW    = ((IB > PW) ? IB : PW) + 1;
  localparam int ACC_W = (IB + 18 > SB + 51) ? IB + 18 : SB + 51;

  localparam logic signed [ACC_W-1:0] LIM_POS  = ACC_W'(TURN_LIMIT) <<< OUT_FRAC;
  localparam logic signed [ACC_W-1:0] LIM_NEG  = -LIM_POS;
  localparam logic signed [ACC_W-1:0] HALF_POS = ACC_W'(1) <<< (OUT_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HALF_NEG = HALF_POS - ACC_W'(1);
  localparam logic signed [IB-1:0]    INT_MAX  = {1'b0, {(IB - 1){1'b1}}};
  localparam logic signed [IB-1:0]    INT_MIN  = {1'b1, {(IB - 1){1'b0}}};
  localparam logic signed [TURN_BITS-1:0] TURN_POS = TURN_BITS'(TURN_LIMIT);
  localparam logic signed [TURN_BITS-1:0] TURN_NEG = -TURN_POS;

  logic [CFG_W-1:0]        gain_p_r, gain_p_nxt;
  logic [CFG_W-1:0]        gain_i_r, gain_i_nxt;
  logic [CFG_W-1:0]        gain_d_r, gain_d_nxt;
  logic [CFG_W-1:0]        period_r, period_nxt;
  logic [RATE_W-1:0]       rate_r, rate_nxt;

  logic                    busy_r, busy_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  psc_out_t                out_data_r, out_data_nxt;

  logic signed [EW-1:0]    err_r, err_nxt;
  logic signed [EW-1:0]    prev_r, prev_nxt;
  logic signed [IB-1:0]    integ_r, integ_nxt;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    clamp_hi_r, clamp_hi_nxt;
  logic                    clamp_lo_r, clamp_lo_nxt;

  psc_uword_t              uw;
  logic                    in_take;
  logic                    out_free;
  logic signed [EW:0]      err_sum;
  logic signed [EW:0]      err_diff;
  logic signed [AW-1:0]    mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;
  logic signed [SW-1:0]    int_sum;
  logic                    int_ovf;

  assign uw       = psc_ucode(step_r);
  assign in_stall = busy_r;
  assign in_take  = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign err_sum  = EW'(err_r) + EW'(prev_r) + (EW + 1)'(0);
  assign err_diff = (EW + 1)'(err_r) - (EW + 1)'(prev_r);

  always_comb begin
    unique case (uw.mul_op)
      MUL_EP: begin
        mul_a = $signed({1'b0, period_r});
        mul_b = MB'(err_sum);
      end
      MUL_P: begin
        mul_a = $signed({1'b0, gain_p_r});
        mul_b = MB'(err_r);
      end
      MUL_DR: begin
        mul_a = $signed({{(AW - RATE_W){1'b0}}, rate_r});
        mul_b = MB'(err_diff);
      end
      MUL_D: begin
        mul_a = $signed({1'b0, gain_d_r});
        mul_b = $signed(prod_r[MB-1:0]);
      end
      MUL_ILO: begin
        mul_a = $signed({1'b0, gain_i_r});
        mul_b = MB'($signed({1'b0, integ_r[LO_W-1:0]}));
      end
      MUL_IHI: begin
        mul_a = $signed({1'b0, gain_i_r});
        mul_b = MB'($signed(integ_r[IB-1:LO_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign int_sum = SW'(integ_r) + SW'(prod_r);
  assign int_ovf = !(&int_sum[SW-1:IB-1]) && (|int_sum[SW-1:IB-1]);

  always_comb begin
    gain_p_nxt    = gain_p_r;
    gain_i_nxt    = gain_i_r;
    gain_d_nxt    = gain_d_r;
    period_nxt    = period_r;
    rate_nxt      = rate_r;
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    err_nxt       = err_r;
    prev_nxt      = prev_r;
    integ_nxt     = integ_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    clamp_hi_nxt  = clamp_hi_r;
    clamp_lo_nxt  = clamp_lo_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:      gain_p_nxt = cfg_wdata;
        CFG_GAIN_I:      gain_i_nxt = cfg_wdata;
        CFG_GAIN_D:      gain_d_nxt = cfg_wdata;
        CFG_PERIOD_FRAC: period_nxt = cfg_wdata;
        CFG_RATE:        rate_nxt   = cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_take) begin
      err_nxt  = $signed({1'b0, in_data.sample_value}) - $signed({1'b0, in_data.target_value});
      busy_nxt = 1'b1;
      step_nxt = '0;
    end

    if (busy_r) begin
      prod_nxt = mul_p;

      unique case (uw.acc_op)
        ACC_NOP: ;
        ACC_INTEG: begin
          if (int_ovf) begin
            integ_nxt = int_sum[SW-1] ? INT_MIN : INT_MAX;
          end else begin
            integ_nxt = int_sum[IB-1:0];
          end
        end
        ACC_LOAD_Q: acc_nxt = ACC_W'(prod_r) <<< INT_FRAC;
        ACC_ADD_Q:  acc_nxt = acc_r + (ACC_W'(prod_r) <<< INT_FRAC);
        ACC_ADD:    acc_nxt = acc_r + ACC_W'(prod_r);
        ACC_ADD_HI: acc_nxt = acc_r + (ACC_W'(prod_r) <<< LO_W);
        ACC_ROUND: begin
          clamp_hi_nxt = acc_r > LIM_POS;
          clamp_lo_nxt = acc_r < LIM_NEG;
          acc_nxt      = acc_r + (acc_r[ACC_W-1] ? HALF_NEG : HALF_POS);
        end
        default: ;
      endcase

      unique case (uw.jmp)
        JMP_NEXT: step_nxt = step_r + STEP_W'(1);
        JMP_DONE: begin
          if (out_free) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.was_clamped = clamp_hi_r || clamp_lo_r;
            priority if (clamp_hi_r) begin
              out_data_nxt.turn_value = TURN_POS;
            end else if (clamp_lo_r) begin
              out_data_nxt.turn_value = TURN_NEG;
            end else begin
              out_data_nxt.turn_value = acc_r[OUT_FRAC+TURN_BITS-1:OUT_FRAC];
            end
            prev_nxt = err_r;
            busy_nxt = 1'b0;
            step_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      period_r    <= PERIOD_RST;
      rate_r      <= RATE_RST;
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      integ_r     <= '0;
    end else begin
      gain_p_r    <= gain_p_nxt;
      gain_i_r    <= gain_i_nxt;
      gain_d_r    <= gain_d_nxt;
      period_r    <= period_nxt;
      rate_r      <= rate_nxt;
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    err_r      <= err_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    clamp_hi_r <= clamp_hi_nxt;
    clamp_lo_r <= clamp_lo_nxt;
  end

endmodule

FILE: sv/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks on the PID steering controller, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_steering_controller_macros.svh"

module psc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input psc_pkg::psc_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input psc_pkg::psc_out_t             out_data,
  input logic                          cfg_we,
  input logic [psc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [psc_pkg::CFG_W-1:0]     cfg_wdata
);
  import psc_pkg::*;

  localparam logic signed [TURN_BITS-1:0] TURN_POS = TURN_BITS'(TURN_LIMIT);
  localparam logic signed [TURN_BITS-1:0] TURN_NEG = -TURN_POS;

  logic unused_ok;
  assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_wdata) ^ (|in_data);

  `PSC_ASSERT_NOW(a_turn_range, out_valid, (out_data.turn_value <= TURN_POS) && (out_data.turn_value >= TURN_NEG))
  `PSC_ASSERT_NOW(a_clamp_limit, out_valid && out_data.was_clamped, (out_data.turn_value == TURN_POS) || (out_data.turn_value == TURN_NEG))
  `PSC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `PSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind pid_steering_controller psc_checker u_psc_checker (.*);

FILE: dv/tb_pid_steering_controller.sv
// ----------------------------------------------------------------------------
// tb_pid_steering_controller
// Self-checking bench for the PID steering controller. A directed table covers
// reset behavior, rounding ties, the clamp boundary, register masking, unused
// register indexes and zero period or rate. Randomized register settings and
// sensor transactions follow, under several sender and receiver stall
// patterns. Untyped results are checked against a bit-exact fixed-point model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pid_steering_controller;
  import psc_pkg::*;

  localparam int INTEG_BITS   = 40;
  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_CYCLES   = 1000000;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 212;
  localparam int MAX_REPORTS  = 10;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;

  localparam longint SUM_MAX   = (longint'(1) << (INTEG_BITS - 1)) - 1;
  localparam longint SUM_MIN   = -SUM_MAX - 1;
  localparam longint FRAC_MASK = (longint'(1) << INT_FRAC) - 1;
  localparam longint TURN_Q12  = longint'(TURN_LIMIT) * 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_W-1:0]            wdata;
    logic [SAMPLE_BITS-1:0]      sample;
    logic [SAMPLE_BITS-1:0]      target;
    logic                        typed;
    logic signed [TURN_BITS-1:0] turn;
    logic                        clamp;
  } plan_row_t;

  localparam plan_row_t PLAN [41] = '{
    '{ROW_ITEM, '0, '0, 10'd512, 10'd512, 1'b1, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd1023, 10'd0, 1'b1, 9'sd200, 1'b1},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd1023, 1'b1, -9'sd200, 1'b1},
    '{ROW_ITEM, '0, '0, 10'd300, 10'd310, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_P, 16'd2048, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_I, 16'd0, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_D, 16'd0, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd1, 10'd0, 1'b1, 9'sd1, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd1, 1'b1, -9'sd1, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd3, 10'd0, 1'b1, 9'sd2, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd3, 1'b1, -9'sd2, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd400, 10'd0, 1'b1, 9'sd200, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd400, 1'b1, -9'sd200, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd401, 10'd0, 1'b1, 9'sd200, 1'b1},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd401, 1'b1, -9'sd200, 1'b1},
    '{ROW_ITEM, '0, '0, 10'd1023, 10'd1023, 1'b1, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_P, 16'd0, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_D, 16'd4096, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_RATE, 16'h4001, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_SPARE_LO, 16'hFFFF, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_SPARE_HI, 16'hFFFF, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd150, 10'd0, 1'b1, 9'sd150, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd150, 10'd0, 1'b1, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd60, 1'b1, -9'sd200, 1'b1},
    '{ROW_CFG, CFG_RATE, 16'hC000, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd1023, 10'd0, 1'b1, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_I, 16'd4096, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_PERIOD_FRAC, 16'hFFFF, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd600, 10'd500, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd500, 10'd600, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd1023, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_PERIOD_FRAC, 16'd0, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd1023, 10'd0, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd0, 10'd1023, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_P, 16'hFFFF, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_I, 16'hFFFF, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_GAIN_D, 16'hFFFF, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_PERIOD_FRAC, 16'd1, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_CFG, CFG_RATE, 16'd10000, '0, '0, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd512, 10'd511, 1'b0, 9'sd0, 1'b0},
    '{ROW_ITEM, '0, '0, 10'd511, 10'd512, 1'b0, 9'sd0, 1'b0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  psc_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  psc_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  longint      gain_p_q;
  longint      gain_i_q;
  longint      gain_d_q;
  longint      period_q;
  longint      rate_q;
  longint      last_err;
  longint      err_sum;
  psc_out_t    steer_q[$];
  int          mismatches;
  int unsigned cycle_count;
  idle_mode_e  idle_mode = IDLE_NONE;

  pid_steering_controller #(.INTEGRAL_BITS(INTEG_BITS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit count_fault();
    mismatches++;
    return mismatches <= MAX_REPORTS;
  endfunction

  function automatic void steer_reset();
    gain_p_q = longint'(GAIN_P_RST);
    gain_i_q = longint'(GAIN_I_RST);
    gain_d_q = longint'(GAIN_D_RST);
    period_q = longint'(PERIOD_RST);
    rate_q   = longint'(RATE_RST);
    last_err = 0;
    err_sum  = 0;
  endfunction

  function automatic void steer_cfg_apply(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_GAIN_P:      gain_p_q = longint'(data);
      CFG_GAIN_I:      gain_i_q = longint'(data);
      CFG_GAIN_D:      gain_d_q = longint'(data);
      CFG_PERIOD_FRAC: period_q = longint'(data);
      CFG_RATE:        rate_q   = longint'(data[RATE_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic psc_out_t steer_predict(psc_in_t d);
    longint   e;
    longint   inc;
    longint   lo_bits;
    longint   lo_prod;
    longint   sum_q12;
    longint   frac;
    longint   scaled;
    longint   turn;
    logic     clamp;
    psc_out_t res;
    e   = longint'(d.sample_value) - longint'(d.target_value);
    inc = (e + last_err) * period_q;
    if (inc > 0 && err_sum > SUM_MAX - inc) begin
      err_sum = SUM_MAX;
    end else if (inc < 0 && err_sum < SUM_MIN - inc) begin
      err_sum = SUM_MIN;
    end else begin
      err_sum = err_sum + inc;
    end
    lo_bits = err_sum & FRAC_MASK;
    lo_prod = gain_i_q * lo_bits;
    sum_q12 = gain_p_q * e + gain_d_q * (e - last_err) * rate_q
              + gain_i_q * (err_sum >>> INT_FRAC) + (lo_prod >>> INT_FRAC);
    frac    = lo_prod & FRAC_MASK;
    clamp   = 1'b0;
    if (sum_q12 > TURN_Q12 || (sum_q12 == TURN_Q12 && frac > 0)) begin
      turn  = TURN_LIMIT;
      clamp = 1'b1;
    end else if (sum_q12 < -TURN_Q12) begin
      turn  = -TURN_LIMIT;
      clamp = 1'b1;
    end else begin
      scaled = (sum_q12 <<< INT_FRAC) + frac;
      if (scaled >= 0) begin
        turn = (scaled + (longint'(1) << (OUT_FRAC - 1))) >>> OUT_FRAC;
      end else begin
        turn = -(((-scaled) + (longint'(1) << (OUT_FRAC - 1))) >>> OUT_FRAC);
      end
    end
    last_err        = e;
    res.turn_value  = turn[TURN_BITS-1:0];
    res.was_clamped = clamp;
    return res;
  endfunction

  function automatic psc_in_t random_item();
    int      s;
    int      t;
    int      span;
    psc_in_t d;
    if (roll(55)) begin
      case ($urandom_range(0, 2))
        0:       span = 8;
        1:       span = 64;
        default: span = 400;
      endcase
      t = int'($urandom_range(0, SAMPLE_MAX));
      s = t + int'($urandom_range(0, 2 * span)) - span;
      if (s < 0) begin
        s = 0;
      end else if (s > SAMPLE_MAX) begin
        s = SAMPLE_MAX;
      end
    end else begin
      s = int'($urandom_range(0, SAMPLE_MAX));
      t = int'($urandom_range(0, SAMPLE_MAX));
    end
    d.sample_value = SAMPLE_BITS'(s);
    d.target_value = SAMPLE_BITS'(t);
    return d;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return roll(72);
      IDLE_BOTH: return roll(8);
      default:   return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_stall <= roll(72);
      IDLE_BOTH: out_stall <= roll(8);
      default:   out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    psc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (steer_q.size() == 0) begin
        if (count_fault()) begin
          $display("unexpected result: turn %0d clamp %0b", out_data.turn_value,
                   out_data.was_clamped);
        end
      end else begin
        want = steer_q.pop_front();
        if (out_data.turn_value !== want.turn_value ||
            out_data.was_clamped !== want.was_clamped) begin
          if (count_fault()) begin
            $display("mismatch: turn exp %0d got %0d, clamp exp %0b got %0b",
                     want.turn_value, out_data.turn_value, want.was_clamped,
                     out_data.was_clamped);
          end
        end
      end
    end
  end

  // hold input low until every result is back and the block has settled
  task automatic wait_for_idle();
    in_valid = 1'b0;
    while (steer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_for_idle();
    cfg_index = idx;
    cfg_wdata = data;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    steer_cfg_apply(idx, data);
  endtask

  task automatic send_item(psc_in_t d, bit typed, psc_out_t typed_res);
    psc_out_t res;
    while (sender_idles()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data  = d;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = steer_predict(d);
    steer_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic set_phase_regs(int phase);
    logic [CFG_W-1:0] gp;
    logic [CFG_W-1:0] gi;
    logic [CFG_W-1:0] gd;
    logic [CFG_W-1:0] per;
    logic [CFG_W-1:0] rate;
    if (phase == 0) begin
      gp   = GAIN_P_RST;
      gi   = GAIN_I_RST;
      gd   = GAIN_D_RST;
      per  = PERIOD_RST;
      rate = CFG_W'(RATE_RST);
    end else if (phase == 1) begin
      gp   = 16'd1;
      gi   = 16'd1;
      gd   = 16'd1;
      per  = 16'd1;
      rate = 16'd1;
    end else if (phase == PHASE_COUNT - 1) begin
      gp   = 16'hFFFF;
      gi   = 16'hFFFF;
      gd   = 16'hFFFF;
      per  = 16'hFFFF;
      rate = 16'hFFFF;
    end else begin
      gp   = roll(20) ? CFG_W'($urandom_range(0, 65535)) : CFG_W'($urandom_range(0, 4095));
      gi   = CFG_W'($urandom_range(0, 2047));
      gd   = CFG_W'($urandom_range(0, 1023));
      per  = CFG_W'($urandom_range(1, 2000));
      rate = CFG_W'($urandom_range(1, 400)) | (CFG_W'($urandom_range(0, 3)) << RATE_W);
    end
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_PERIOD_FRAC, per);
    write_reg(CFG_RATE, rate);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    plan_row_t row;
    psc_in_t   d;
    psc_out_t  typed_res;
    int        n;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    mismatches = 0;
    steer_reset();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    foreach (PLAN[i]) begin
      row = PLAN[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.wdata);
      end else begin
        d.sample_value        = row.sample;
        d.target_value        = row.target;
        typed_res.turn_value  = row.turn;
        typed_res.was_clamped = row.clamp;
        send_item(d, row.typed, typed_res);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_mode = IDLE_NONE;
      set_phase_regs(p);
      idle_mode = idle_mode_e'(p % 4);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 149) == 0) begin
          wait_for_idle();
        end
        send_item(random_item(), 1'b0, '0);
      end
    end

    idle_mode = IDLE_NONE;
    in_valid = 1'b0;
    while (steer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
